FILE: hdl/ema_deviation_rate_anomaly_detector_assert.svh
// Assertion macros shared by the checker of the EMA deviation rate detector.
// Each macro takes a label, a clock, a reset, an antecedent and a consequent.
`ifndef EMA_DEVIATION_RATE_ANOMALY_DETECTOR_ASSERT_SVH
`define EMA_DEVIATION_RATE_ANOMALY_DETECTOR_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define EDR_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("edr assertion failed");

// Next-cycle implication, disabled during reset.
`define EDR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("edr assertion failed");

`endif

FILE: hdl/edr_pkg.sv
// Shared types and constants of the EMA deviation rate anomaly detector.
// Used by the register block, the update datapath and the top level.
`default_nettype none

package edr_pkg;

   localparam int RATE_W  = 32;
   localparam int LEVEL_W = 48;
   localparam int COUNT_W = 16;
   localparam int GAIN_W  = 17;
   localparam int BAND_W  = 16;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 17;

   localparam logic [CSR_INDEX_W-1:0] REG_MEAN_GAIN      = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_DEVIATION_GAIN = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_BAND_WIDTH     = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_WARMUP_SAMPLES = 2'd3;

   localparam logic [GAIN_W-1:0]  ONE_Q16          = 17'h10000;
   localparam logic [GAIN_W-1:0]  RESET_MEAN_GAIN  = 17'd6554;
   localparam logic [GAIN_W-1:0]  RESET_DEV_GAIN   = 17'd6554;
   localparam logic [BAND_W-1:0]  RESET_BAND_WIDTH = 16'd768;
   localparam logic [COUNT_W-1:0] RESET_WARMUP     = 16'd10;
   localparam logic [COUNT_W-1:0] COUNT_MAX        = 16'hFFFF;

   typedef struct packed {
      logic [GAIN_W-1:0]  mean_gain;
      logic [GAIN_W-1:0]  deviation_gain;
      logic [BAND_W-1:0]  band_width;
      logic [COUNT_W-1:0] warmup_samples;
   } cfg_type;

   typedef struct packed {
      logic [LEVEL_W-1:0] mean_level;
      logic [LEVEL_W-1:0] spread_level;
      logic [COUNT_W-1:0] sample_count;
   } state_type;

endpackage

`default_nettype wire

FILE: hdl/edr_csr.sv
// Configuration registers of the EMA deviation rate anomaly detector.
// Depends on edr_pkg for the register layout, indexes and reset values.
`default_nettype none

module edr_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [edr_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [edr_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output edr_pkg::cfg_type                 cfg
);
   import edr_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            REG_MEAN_GAIN:      cfg_in.mean_gain      = csr_wdata;
            REG_DEVIATION_GAIN: cfg_in.deviation_gain = csr_wdata;
            REG_BAND_WIDTH:     cfg_in.band_width     = csr_wdata[BAND_W-1:0];
            REG_WARMUP_SAMPLES: cfg_in.warmup_samples = csr_wdata[COUNT_W-1:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mean_gain      <= RESET_MEAN_GAIN;
         cfg_ff.deviation_gain <= RESET_DEV_GAIN;
         cfg_ff.band_width     <= RESET_BAND_WIDTH;
         cfg_ff.warmup_samples <= RESET_WARMUP;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

FILE: hdl/edr_core.sv
// Single-pass update datapath: band check and both EMA updates for one word.
// Depends on edr_pkg for the state and configuration structs.
`default_nettype none

module edr_core (
   input  logic [edr_pkg::RATE_W-1:0]  rate,
   input  edr_pkg::cfg_type            cfg,
   input  edr_pkg::state_type          state_now,
   output edr_pkg::state_type          state_next,
   output logic                        alert
);
   import edr_pkg::*;

   // old + floor(gain * (fresh - old) / 2^16), equal to the weighted blend
   // of fresh and old truncated to Q32.16; the result never leaves 48 bits.
   function automatic logic [LEVEL_W-1:0] blend(logic [GAIN_W-1:0] gain,
                                               logic [LEVEL_W-1:0] fresh,
                                               logic [LEVEL_W-1:0] old);
      logic signed [LEVEL_W:0]        step;
      logic signed [GAIN_W+LEVEL_W:0] prod;
      logic signed [GAIN_W+LEVEL_W:0] scaled;
      logic [LEVEL_W-1:0]             sum;
      step   = $signed({1'b0, fresh}) - $signed({1'b0, old});
      prod   = $signed({1'b0, gain}) * step;
      scaled = prod >>> 16;
      sum    = old + scaled[LEVEL_W-1:0];
      return sum;
   endfunction

   logic [LEVEL_W-1:0]        rate_q;
   logic [LEVEL_W-1:0]        diff;
   logic                      above;
   logic                      first;
   logic [GAIN_W-1:0]         mean_gain_c;
   logic [GAIN_W-1:0]         dev_gain_c;
   logic [BAND_W+LEVEL_W-1:0] band_prod;
   logic [BAND_W+LEVEL_W-9:0] band;
   logic                      armed;

   assign rate_q = {rate, 16'b0};
   assign above  = rate_q > state_now.mean_level;
   assign diff   = above ? (rate_q - state_now.mean_level)
                         : (state_now.mean_level - rate_q);
   assign first  = state_now.sample_count == '0;

   assign mean_gain_c = (cfg.mean_gain > ONE_Q16) ? ONE_Q16 : cfg.mean_gain;
   assign dev_gain_c  = (cfg.deviation_gain > ONE_Q16) ? ONE_Q16 : cfg.deviation_gain;

   assign band_prod = cfg.band_width * state_now.spread_level;
   assign band      = band_prod[BAND_W+LEVEL_W-1:8];

   assign armed = !first
               && (state_now.sample_count >= cfg.warmup_samples)
               && (state_now.spread_level >= LEVEL_W'(ONE_Q16));
   assign alert = armed && above && ({8'b0, diff} > band);

   always_comb begin
      state_next = state_now;
      if (first) begin
         state_next.mean_level   = rate_q;
         state_next.spread_level = '0;
         state_next.sample_count = COUNT_W'(1);
      end else begin
         if (!alert) begin
            state_next.mean_level   = blend(mean_gain_c, rate_q, state_now.mean_level);
            state_next.spread_level = blend(dev_gain_c, diff, state_now.spread_level);
         end
         if (state_now.sample_count != COUNT_MAX) begin
            state_next.sample_count = state_now.sample_count + COUNT_W'(1);
         end
      end
   end

endmodule

`default_nettype wire

FILE: hdl/ema_deviation_rate_anomaly_detector.sv
// An accepted request word is held in the input stage, and its response word in the response register.
// Throughput: one word per cycle unless rsp_tready stalls; the feedback is one state register.
// Reset (synchronous, active high) empties both stages, clears the mean, deviation
// and sample count to zero and restores the configuration register defaults.
// Depends on edr_pkg, edr_csr and edr_core.
`default_nettype none

module ema_deviation_rate_anomaly_detector (
   input  logic          clock,
   input  logic          reset,
   // Request channel. tdata: [31:0] rate.
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [31:0]   req_tdata,
   // Response channel. tdata: [0] alert, [48:1] mean_now, [96:49] deviation_now,
   // [103:97] zero fill.
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [103:0]  rsp_tdata,
   // Configuration write port.
   input  logic          csr_we,
   input  logic [1:0]    csr_index,
   input  logic [16:0]   csr_wdata
);
   import edr_pkg::*;

   // The design is a two-stage pipe. The first stage holds the incoming rate;
   // the second is the response register. Moving a word from the first stage to
   // the second is the moment the detector state is read and updated, so each
   // word sees the state left by the word just ahead of it.

   cfg_type            cfg;
   state_type          state_ff;
   state_type          state_in;
   state_type          state_next;
   logic               alert_now;

   logic               s1_valid_ff;
   logic               s1_valid_in;
   logic [RATE_W-1:0]  s1_rate_ff;
   logic [RATE_W-1:0]  s1_rate_in;

   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   logic               rsp_alert_ff;
   logic               rsp_alert_in;
   logic [LEVEL_W-1:0] rsp_mean_ff;
   logic [LEVEL_W-1:0] rsp_mean_in;
   logic [LEVEL_W-1:0] rsp_dev_ff;
   logic [LEVEL_W-1:0] rsp_dev_in;

   logic               advance;
   logic               fire;
   logic               req_take;

   edr_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   edr_core u_core (
      .rate       (s1_rate_ff),
      .cfg        (cfg),
      .state_now  (state_ff),
      .state_next (state_next),
      .alert      (alert_now)
   );

   // The response register may load whenever it is empty or being drained,
   // and the input stage may load whenever it is empty or moving forward.
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign fire       = s1_valid_ff && advance;
   assign req_tready = !s1_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_rate_in  = s1_rate_ff;
      if (req_take) begin
         s1_valid_in = 1'b1;
         s1_rate_in  = req_tdata;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_alert_in = rsp_alert_ff;
      rsp_mean_in  = rsp_mean_ff;
      rsp_dev_in   = rsp_dev_ff;
      if (advance) begin
         rsp_valid_in = s1_valid_ff;
      end
      if (fire) begin
         state_in     = state_next;
         rsp_alert_in = alert_now;
         rsp_mean_in  = state_next.mean_level;
         rsp_dev_in   = state_next.spread_level;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         state_ff     <= state_in;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      s1_rate_ff   <= s1_rate_in;
      rsp_alert_ff <= rsp_alert_in;
      rsp_mean_ff  <= rsp_mean_in;
      rsp_dev_ff   <= rsp_dev_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'b0, rsp_dev_ff, rsp_mean_ff, rsp_alert_ff};

endmodule

`default_nettype wire

FILE: hdl/edr_checker.sv
// Port-level checker for the EMA deviation rate anomaly detector, with its bind.
// Depends on ema_deviation_rate_anomaly_detector_assert.svh for the macros.
`default_nettype none

`include "ema_deviation_rate_anomaly_detector_assert.svh"

module edr_checker (
   input logic          clock,
   input logic          reset,
   input logic          req_tready,
   input logic          rsp_tvalid,
   input logic          rsp_tready,
   input logic [103:0]  rsp_tdata
);

   // A stalled response word stays put.
   `EDR_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))

   // An alert freezes the deviation, which had to be at least 1.0 to arm it.
   `EDR_ASSERT_SAME(a_alert_dev, clock, reset, rsp_tvalid && rsp_tdata[0], rsp_tdata[96:49] >= 48'h10000)

   // With the response register empty the pipe can always take a word.
   `EDR_ASSERT_SAME(a_ready_empty, clock, reset, !rsp_tvalid, req_tready)

endmodule

bind ema_deviation_rate_anomaly_detector edr_checker u_edr_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire

FILE: verif/ema_deviation_rate_anomaly_detector_tb.sv
// Self-checking testbench of the EMA deviation rate anomaly detector.
// Drives rate words, predicts every response word and compares field by field.
// Depends on edr_pkg and the ema_deviation_rate_anomaly_detector top level.
`default_nettype none

module ema_deviation_rate_anomaly_detector_tb;

   import edr_pkg::*;

   // Run length and pacing. The block answers each request word from its response register,
   // so SETTLE_CYCLES of quiet after the last response let it settle.
   localparam int unsigned CYCLE_LIMIT   = 1000000;
   localparam int unsigned SETTLE_CYCLES = 4;
   localparam int unsigned PHASE_COUNT   = 8;
   localparam int unsigned PHASE_WORDS   = 240;
   localparam int unsigned LONG_HOLD     = 150;

   // One response word as the block packs it, alert in the lowest bit.
   typedef struct packed {
      logic [LEVEL_W-1:0] deviation_now;
      logic [LEVEL_W-1:0] mean_now;
      logic               alert;
   } detector_result_t;

   // One row of the directed part: a register write or a rate word, with
   // an optional hand-written expectation.
   typedef struct packed {
      logic                   is_write;
      logic [CSR_INDEX_W-1:0] index;
      logic [31:0]            value;
      logic                   typed;
      detector_result_t       want;
   } stimulus_row_t;

   // All block inputs hold known values from time zero.
   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [RATE_W-1:0]      req_tdata  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [103:0]           rsp_tdata;
   logic                   csr_we     = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index  = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata  = '0;

   // Shadow copy of the block's registers and trackers.
   cfg_type   model_cfg;
   state_type model_state;

   detector_result_t pending_results[$];
   stimulus_row_t    directed_rows[$];

   int unsigned mismatch_count = 0;
   int unsigned cycle_count    = 0;

   // Traffic shape of the current phase.
   logic [63:0] phase_base   = 64'd100;
   int unsigned phase_jitter = 13;
   bit          sender_calm  = 1'b0;

   // Receiver state: its own idling and its long hold-offs.
   int          rx_words     = 0;
   int          next_hold_at = 400;
   int unsigned hold_left    = 0;
   int unsigned rx_gap       = 0;
   int unsigned rx_cycles    = 0;
   bit          rx_calm      = 1'b0;

   ema_deviation_rate_anomaly_detector dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // A hung handshake ends the run here.
   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("TEST FAILED");
      $finish;
   end

   // Weighted blend of a fresh value and an old level. Gains above 1.0 act
   // as exactly 1.0, and the sum is truncated back to Q32.16.
   function automatic logic [LEVEL_W-1:0] blend_level(input logic [GAIN_W-1:0] gain,
                                                      input logic [LEVEL_W-1:0] fresh,
                                                      input logic [LEVEL_W-1:0] old);
      logic [63:0] g;
      logic [63:0] acc;
      g   = (gain > ONE_Q16) ? {47'd0, ONE_Q16} : {47'd0, gain};
      acc = g * {16'd0, fresh} + ({47'd0, ONE_Q16} - g) * {16'd0, old};
      return acc[63:16];
   endfunction

   // Advances the shadow trackers by one rate word and returns the
   // response word the block must produce for it.
   function automatic detector_result_t advance_detector(input logic [RATE_W-1:0] rate);
      logic [63:0]      scaled;
      logic [63:0]      prior;
      logic [63:0]      gap_abs;
      logic [63:0]      band;
      logic             raise;
      detector_result_t res;
      scaled = {16'd0, rate, 16'd0};
      raise  = 1'b0;
      if (model_state.sample_count == '0) begin
         // The very first word seeds the average and clears the deviation.
         model_state.mean_level   = scaled[LEVEL_W-1:0];
         model_state.spread_level = '0;
         model_state.sample_count = 16'd1;
      end else begin
         prior   = {16'd0, model_state.mean_level};
         gap_abs = (scaled >= prior) ? scaled - prior : prior - scaled;
         // Alerts need a finished warmup and a deviation of at least 1.0.
         if (model_state.sample_count >= model_cfg.warmup_samples &&
             model_state.spread_level >= ONE_Q16) begin
            band = ({48'd0, model_cfg.band_width} * {16'd0, model_state.spread_level}) >> 8;
            if (scaled > prior && (scaled - prior) > band) begin
               raise = 1'b1;
            end
         end
         // An alert freezes both trackers; otherwise both use the old mean.
         if (!raise) begin
            model_state.mean_level = blend_level(model_cfg.mean_gain,
                                                 scaled[LEVEL_W-1:0], prior[LEVEL_W-1:0]);
            model_state.spread_level = blend_level(model_cfg.deviation_gain,
                                                   gap_abs[LEVEL_W-1:0],
                                                   model_state.spread_level);
         end
         if (model_state.sample_count != COUNT_MAX) begin
            model_state.sample_count = model_state.sample_count + 16'd1;
         end
      end
      res.alert         = raise;
      res.mean_now      = model_state.mean_level;
      res.deviation_now = model_state.spread_level;
      return res;
   endfunction

   // Idle lengths: mostly none or short, now and then a long one.
   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) begin
         return 0;
      end else if (roll < 90) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [GAIN_W-1:0] pick_gain();
      case ($urandom_range(0, 4))
         0: return '0;
         1: return ONE_Q16;
         2: return GAIN_W'($urandom_range(0, 131071));
         default: return GAIN_W'($urandom_range(256, 20000));
      endcase
   endfunction

   // Mostly steady traffic around the phase base, with spikes that should
   // trip the band, plus a share of raw noise and of the rate extremes.
   function automatic logic [RATE_W-1:0] draw_rate();
      int unsigned roll;
      logic [63:0] v;
      roll = $urandom_range(0, 99);
      if (roll < 6) begin
         v = phase_base * 3 + {32'd0, phase_jitter} * 8 + 64'd64;
      end else if (roll < 10) begin
         v = {32'd0, $urandom()};
      end else if (roll == 10) begin
         v = 64'd0;
      end else if (roll == 11) begin
         v = 64'hFFFF_FFFF;
      end else begin
         v = phase_base + 64'($urandom_range(0, 2 * phase_jitter));
         v = (v >= phase_jitter) ? v - phase_jitter : 64'd0;
      end
      if (v > 64'hFFFF_FFFF) begin
         v = 64'hFFFF_FFFF;
      end
      return v[RATE_W-1:0];
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      mismatch_count++;
      $display("ERROR: %s: got %h, want %h (response word %0d)", what, got, want,
               rx_words);
   endtask

   // Compares one accepted response word with the oldest expectation.
   task automatic check_word(input logic [103:0] word);
      detector_result_t want;
      if (pending_results.size() == 0) begin
         report_mismatch("response word with nothing pending", word[63:0], 64'd0);
      end else begin
         want = pending_results.pop_front();
         if (word[0] !== want.alert) begin
            report_mismatch("alert", {63'd0, word[0]}, {63'd0, want.alert});
         end
         if (word[48:1] !== want.mean_now) begin
            report_mismatch("mean_now", {16'd0, word[48:1]}, {16'd0, want.mean_now});
         end
         if (word[96:49] !== want.deviation_now) begin
            report_mismatch("deviation_now", {16'd0, word[96:49]},
                            {16'd0, want.deviation_now});
         end
         if (word[103:97] !== 7'd0) begin
            report_mismatch("zero fill", {57'd0, word[103:97]}, 64'd0);
         end
      end
   endtask

   // Receiver: checks every accepted response word, then decides the ready
   // level for the next cycle. Two long hold-offs are counted here while
   // the sender keeps offering, so the block fills and stalls its input.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         check_word(rsp_tdata);
         rx_words++;
      end
      rx_cycles++;
      if (rx_cycles % 200 == 0) begin
         rx_calm = ($urandom_range(0, 2) == 0);
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (rx_words == next_hold_at) begin
         hold_left    = LONG_HOLD - 1;
         next_hold_at = (next_hold_at == 400) ? 1100 : -1;
         rsp_tready <= 1'b0;
      end else if (rx_gap > 0) begin
         rx_gap--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         if (!rx_calm && $urandom_range(0, 3) == 0) begin
            rx_gap = pick_gap();
         end
      end
   end

   // Offers one rate word and waits for it to be accepted. The prediction
   // is made at the accepting edge; a typed row overrides it.
   task automatic offer_rate(input logic [RATE_W-1:0] rate, input logic typed,
                             input detector_result_t want);
      detector_result_t predicted;
      req_tdata  <= rate;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) begin
         @(posedge clock);
      end
      predicted = advance_detector(rate);
      pending_results.push_back(typed ? want : predicted);
   endtask

   // Optional idle after a word. A zero gap leaves tvalid high so that the
   // next word follows back to back.
   task automatic sender_idle();
      int unsigned g;
      g = sender_calm ? 0 : pick_gap();
      if (g > 0) begin
         req_tvalid <= 1'b0;
         repeat (g) @(posedge clock);
      end
   endtask

   // Stops offering and waits until every expected word has arrived, then
   // lets the pipeline settle. Register writes only follow this.
   task automatic wait_for_drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // One register write, followed by a quiet cycle so that back-to-back
   // calls never lower and raise the write enable in one step.
   task automatic write_register(input logic [CSR_INDEX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      case (idx)
         REG_MEAN_GAIN:      model_cfg.mean_gain      = data;
         REG_DEVIATION_GAIN: model_cfg.deviation_gain = data;
         REG_BAND_WIDTH:     model_cfg.band_width     = data[BAND_W-1:0];
         REG_WARMUP_SAMPLES: model_cfg.warmup_samples = data[COUNT_W-1:0];
         default: ;
      endcase
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   function automatic void add_rate(input logic [31:0] rate);
      stimulus_row_t row;
      row       = '0;
      row.value = rate;
      directed_rows.push_back(row);
   endfunction

   function automatic void add_rate_typed(input logic [31:0] rate, input logic alert,
                                          input logic [LEVEL_W-1:0] mean,
                                          input logic [LEVEL_W-1:0] dev);
      stimulus_row_t row;
      row                    = '0;
      row.value              = rate;
      row.typed              = 1'b1;
      row.want.alert         = alert;
      row.want.mean_now      = mean;
      row.want.deviation_now = dev;
      directed_rows.push_back(row);
   endfunction

   function automatic void add_write(input logic [CSR_INDEX_W-1:0] idx,
                                     input logic [31:0] data);
      stimulus_row_t row;
      row          = '0;
      row.is_write = 1'b1;
      row.index    = idx;
      row.value    = data;
      directed_rows.push_back(row);
   endfunction

   // Directed part. With both gains at 1.0 the mean follows the rate and
   // the deviation is the step size, so most rows can be read off by hand.
   function automatic void build_directed_rows();
      // First sample after reset seeds the mean and never alerts.
      add_rate_typed(32'd0, 1'b0, '0, '0);
      // Still in warmup under the reset defaults, with the rate extremes.
      add_rate(32'hFFFF_FFFF);
      add_rate(32'd0);
      add_rate(32'd1);
      add_write(REG_MEAN_GAIN, 32'h10000);
      add_write(REG_DEVIATION_GAIN, 32'h10000);
      add_write(REG_BAND_WIDTH, 32'd0);
      add_write(REG_WARMUP_SAMPLES, 32'd0);
      add_rate(32'd100);
      add_rate_typed(32'd100, 1'b0, 48'd100 << 16, '0);
      // Deviation below 1.0 suppresses the alert on this rise.
      add_rate_typed(32'd200, 1'b0, 48'd200 << 16, 48'd100 << 16);
      // Now the deviation is large enough, the band is zero: alert, freeze.
      add_rate_typed(32'd300, 1'b1, 48'd200 << 16, 48'd100 << 16);
      add_rate_typed(32'd200, 1'b0, 48'd200 << 16, '0);
      add_rate(32'hFFFF_FFFF);
      add_rate_typed(32'd0, 1'b0, '0, 48'hFFFF_FFFF_0000);
      // Zero gains hold both trackers.
      add_write(REG_MEAN_GAIN, 32'd0);
      add_write(REG_DEVIATION_GAIN, 32'd0);
      add_rate_typed(32'd0, 1'b0, '0, 48'hFFFF_FFFF_0000);
      add_rate_typed(32'd7, 1'b1, '0, 48'hFFFF_FFFF_0000);
      // Widest band, longest warmup, and gains above 1.0 that act as 1.0.
      add_write(REG_BAND_WIDTH, 32'hFFFF);
      add_write(REG_WARMUP_SAMPLES, 32'hFFFF);
      add_write(REG_MEAN_GAIN, 32'h1FFFF);
      add_write(REG_DEVIATION_GAIN, 32'h10001);
      add_rate_typed(32'd12345, 1'b0, 48'd12345 << 16, 48'd12345 << 16);
      add_rate(32'hA5A5_A5A5);
      add_rate(32'h5A5A_5A5A);
   endfunction

   // Writes all four registers for a random phase and picks its traffic.
   // The first phases pin the defaults and the extremes.
   task automatic start_phase(input int unsigned phase);
      logic [GAIN_W-1:0]  mg;
      logic [GAIN_W-1:0]  dg;
      logic [BAND_W-1:0]  bw;
      logic [COUNT_W-1:0] wu;
      case (phase)
         0: begin
            mg = RESET_MEAN_GAIN;
            dg = RESET_DEV_GAIN;
            bw = RESET_BAND_WIDTH;
            wu = RESET_WARMUP;
         end
         1: begin
            mg = 17'h1FFFF;
            dg = '0;
            bw = '0;
            wu = '0;
         end
         2: begin
            mg = '0;
            dg = ONE_Q16;
            bw = 16'hFFFF;
            wu = 16'hFFFF;
         end
         default: begin
            mg = pick_gain();
            dg = pick_gain();
            case ($urandom_range(0, 3))
               0: bw = BAND_W'($urandom_range(0, 65535));
               1: bw = '0;
               default: bw = BAND_W'($urandom_range(128, 1024));
            endcase
            // A warmup just ahead of the count ends in the middle of the phase.
            case ($urandom_range(0, 2))
               0: wu = COUNT_W'(model_state.sample_count + $urandom_range(0, 150));
               1: wu = '0;
               default: wu = COUNT_W'($urandom_range(0, 65535));
            endcase
         end
      endcase
      write_register(REG_MEAN_GAIN, mg);
      write_register(REG_DEVIATION_GAIN, dg);
      write_register(REG_BAND_WIDTH, {1'b0, bw});
      write_register(REG_WARMUP_SAMPLES, {1'b0, wu});
      case ($urandom_range(0, 2))
         0: phase_base = 64'($urandom_range(0, 200));
         1: phase_base = 64'($urandom_range(1000, 1000000));
         default: phase_base = 64'($urandom_range(32'h0100_0000, 32'hF000_0000));
      endcase
      phase_jitter = phase_base[31:0] / 8 + 1;
   endtask

   initial begin
      stimulus_row_t row;

      model_cfg.mean_gain      = RESET_MEAN_GAIN;
      model_cfg.deviation_gain = RESET_DEV_GAIN;
      model_cfg.band_width     = RESET_BAND_WIDTH;
      model_cfg.warmup_samples = RESET_WARMUP;
      model_state              = '0;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      build_directed_rows();
      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         if (row.is_write) begin
            wait_for_drain();
            write_register(row.index, row.value[CSR_DATA_W-1:0]);
         end else begin
            offer_rate(row.value, row.typed, row.want);
            sender_idle();
         end
      end

      // Random phases, each under its own register setting. Every phase
      // starts only once the previous one has fully drained.
      for (int unsigned p = 0; p < PHASE_COUNT; p++) begin
         wait_for_drain();
         start_phase(p);
         for (int unsigned k = 0; k < PHASE_WORDS; k++) begin
            if (k % 64 == 0) begin
               sender_calm = ($urandom_range(0, 2) == 0);
            end
            offer_rate(draw_rate(), 1'b0, '0);
            sender_idle();
         end
      end

      wait_for_drain();
      if (mismatch_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire

FILE: sim.f
+incdir+hdl
hdl/edr_pkg.sv
hdl/edr_csr.sv
hdl/edr_core.sv
hdl/ema_deviation_rate_anomaly_detector.sv
hdl/edr_checker.sv
verif/ema_deviation_rate_anomaly_detector_tb.sv
